// ----- hdl/cbr_pkg.sv -----
package cbr_pkg;

  // Item format: signed fixed point
  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;

  // Bracket bounds must also hold +/-1.0 when the fraction is wide
  localparam int BW    = (DATA_WIDTH > FRAC_BITS + 2) ? DATA_WIDTH : FRAC_BITS + 2;
  localparam int MW    = BW;
  localparam int SQW   = 2 * MW;
  localparam int CUBEW = 3 * MW;
  localparam int XSW   = MW + 2 * FRAC_BITS;
  localparam int CMPW  = (CUBEW > XSW) ? CUBEW : XSW;

  // Tolerance register
  localparam int TOL_W = 17;
  localparam logic [TOL_W-1:0] TOL_RST = TOL_W'(655);

  // Multiplier operand selection
  localparam logic [1:0] MUL_SQ = 2'd0;
  localparam logic [1:0] MUL_LO = 2'd1;
  localparam logic [1:0] MUL_HI = 2'd2;

  typedef struct packed {
    logic       load;
    logic       mid_load;
    logic       mul_en;
    logic [1:0] mul_sel;
    logic       update;
    logic       finish;
  } cbr_cmd_t;

  typedef struct packed {
    logic go;
  } cbr_stat_t;

endpackage

// ----- hdl/cbr_if.sv -----
interface cbr_in_if;
  import cbr_pkg::*;
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] value;
  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

interface cbr_out_if;
  import cbr_pkg::*;
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] root;
  modport source (output valid, output root, input ready);
  modport sink (input valid, input root, output ready);
endinterface

// ----- hdl/cbr_dp.sv -----
module cbr_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  cbr_pkg::cbr_cmd_t                   cmd,
  output cbr_pkg::cbr_stat_t                  stat,
  input  logic                                cfg_we,
  input  logic [cbr_pkg::TOL_W-1:0]           cfg_wdata,
  input  logic signed [cbr_pkg::DATA_WIDTH-1:0] in_value,
  output logic signed [cbr_pkg::DATA_WIDTH-1:0] root
);
  import cbr_pkg::*;

  localparam logic signed [BW-1:0] ONE_Q     = BW'(1 << FRAC_BITS);
  localparam logic signed [BW-1:0] NEG_ONE_Q = -ONE_Q;

  logic [TOL_W-1:0]             tol_r;
  logic signed [BW-1:0]         x_r;
  logic [MW-1:0]                magx_r;
  logic signed [BW-1:0]         left_r;
  logic signed [BW-1:0]         right_r;
  logic signed [BW-1:0]         mid_r;
  logic [MW-1:0]                mag_r;
  logic [SQW-1:0]               sq_r;
  logic [SQW-1:0]               lo_r;
  logic [SQW-1:0]               hi_r;
  logic signed [DATA_WIDTH-1:0] root_r;

  logic signed [BW-1:0] x_ext_c;
  logic signed [BW-1:0] left_c;
  logic signed [BW-1:0] right_c;
  logic [MW-1:0]        magx_c;
  logic signed [BW:0]   sum_c;
  logic signed [BW-1:0] mid_c;
  logic [MW-1:0]        mag_c;
  logic [BW:0]          diff_c;
  logic [TOL_W-1:0]     tol_eff_c;
  logic [MW-1:0]        mul_a_c;
  logic [SQW-1:0]       prod_c;
  logic [CMPW-1:0]      cube_c;
  logic [CMPW-1:0]      xs_c;
  logic                 mid_neg_c;
  logic                 x_neg_c;
  logic                 above_c;

  // Initial bracket [min(-1,x), max(1,x)]
  assign x_ext_c = BW'(in_value);
  assign left_c  = (x_ext_c < NEG_ONE_Q) ? x_ext_c : NEG_ONE_Q;
  assign right_c = (x_ext_c > ONE_Q) ? x_ext_c : ONE_Q;
  assign magx_c  = x_ext_c[BW-1] ? MW'(~x_ext_c + 1'b1) : MW'(x_ext_c);

  // Midpoint, rounded toward minus infinity
  assign sum_c = {left_r[BW-1], left_r} + {right_r[BW-1], right_r};
  assign mid_c = sum_c[BW:1];
  assign mag_c = mid_c[BW-1] ? MW'(~mid_c + 1'b1) : MW'(mid_c);

  // Keep bisecting while the bracket is wider than the tolerance
  assign diff_c    = {right_r[BW-1], right_r} - {left_r[BW-1], left_r};
  assign tol_eff_c = (tol_r == '0) ? TOL_W'(1) : tol_r;
  assign stat.go   = diff_c > (BW + 1)'(tol_eff_c);

  // Shared multiplier: square, then low and high halves times the magnitude
  always_comb begin
    unique case (cmd.mul_sel)
      MUL_SQ:  mul_a_c = mag_r;
      MUL_LO:  mul_a_c = sq_r[MW-1:0];
      MUL_HI:  mul_a_c = sq_r[SQW-1:MW];
      default: mul_a_c = mag_r;
    endcase
  end
  assign prod_c = SQW'(mul_a_c) * SQW'(mag_r);

  // Compare mid^3 against x scaled to the cube's fraction
  assign cube_c    = (CMPW'(hi_r) << MW) + CMPW'(lo_r);
  assign xs_c      = CMPW'(magx_r) << (2 * FRAC_BITS);
  assign mid_neg_c = mid_r[BW-1];
  assign x_neg_c   = x_r[BW-1];

  always_comb begin
    priority if (!mid_neg_c && x_neg_c) begin
      above_c = 1'b1;
    end else if (mid_neg_c && !x_neg_c) begin
      above_c = 1'b0;
    end else if (mid_neg_c) begin
      above_c = cube_c < xs_c;
    end else begin
      above_c = cube_c > xs_c;
    end
  end

  // Tolerance register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= TOL_RST;
    end else if (cfg_we) begin
      tol_r <= cfg_wdata;
    end
  end

  // Bracket, midpoint and products
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_r     <= x_ext_c;
      magx_r  <= magx_c;
      left_r  <= left_c;
      right_r <= right_c;
    end else if (cmd.update) begin
      if (above_c) begin
        right_r <= mid_r;
      end else begin
        left_r <= mid_r;
      end
    end
    if (cmd.mid_load) begin
      mid_r <= mid_c;
      mag_r <= mag_c;
    end
    if (cmd.mul_en && cmd.mul_sel == MUL_SQ) begin
      sq_r <= prod_c;
    end
    if (cmd.mul_en && cmd.mul_sel == MUL_LO) begin
      lo_r <= prod_c;
    end
    if (cmd.mul_en && cmd.mul_sel == MUL_HI) begin
      hi_r <= prod_c;
    end
    if (cmd.finish) begin
      root_r <= mid_r[DATA_WIDTH-1:0];
    end
  end

  assign root = root_r;

  // The updated bound is the midpoint just tested
  a_update_takes_mid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.update |=> (left_r == $past(mid_r) || right_r == $past(mid_r)))
    else $error("bound update did not take the midpoint");

  // A midpoint never leaves the bracket
  a_mid_in_bracket: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mid_load |=> (mid_r >= left_r && mid_r <= right_r))
    else $error("midpoint outside bracket");

  // The bracket stays ordered whenever a midpoint is taken
  a_bracket_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mid_load |-> left_r <= right_r)
    else $error("bracket bounds out of order");

endmodule

// ----- hdl/cbr_ctrl.sv -----
module cbr_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  cbr_pkg::cbr_stat_t stat,
  output cbr_pkg::cbr_cmd_t  cmd
);
  import cbr_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_START = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_SQ    = 3'd3;
  localparam logic [2:0] S_LO    = 3'd4;
  localparam logic [2:0] S_HI    = 3'd5;
  localparam logic [2:0] S_CMP   = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic       out_valid_r;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  // Load, bisection steps (midpoint, square, two partial cubes, compare), finish
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_START;
        end
      end
      S_START: begin
        cmd.mid_load = 1'b1;
        state_nxt    = stat.go ? S_SQ : S_DONE;
      end
      S_CHECK: begin
        if (stat.go) begin
          cmd.mid_load = 1'b1;
          state_nxt    = S_SQ;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_SQ: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_SQ;
        state_nxt   = S_LO;
      end
      S_LO: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_LO;
        state_nxt   = S_HI;
      end
      S_HI: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_HI;
        state_nxt   = S_CMP;
      end
      S_CMP: begin
        cmd.update = 1'b1;
        state_nxt  = S_CHECK;
      end
      S_DONE: begin
        // Hold until the output register is free
        if (!out_valid_r || out_ready) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  a_sq_then_lo: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SQ |=> state_r == S_LO)
    else $error("square not followed by low partial product");

  a_finish_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> (out_valid_r && state_r == S_IDLE))
    else $error("finished item not presented");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> state_r == S_START)
    else $error("accepted item did not start");

endmodule

// ----- hdl/cube_root_bisection_top.sv -----
// Cube root by bisection, one item at a time.
// Each item runs bisection steps until the bracket fits the tolerance (none when
// the initial bracket already fits); each step needs three passes through one
// shared multiplier for the cube. A new item is taken only after the last finishes;
// a finished result may wait in its register.
// Reset (rst_n, synchronous): controller idle, no result valid, tolerance back to 655.
module cube_root_bisection_top (
  input  logic                       clk,
  input  logic                       rst_n,
  cbr_in_if.sink                     in_item,
  cbr_out_if.source                  out_item,
  input  logic                       cfg_we,
  input  logic [cbr_pkg::TOL_W-1:0]  cfg_wdata
);
  import cbr_pkg::*;

  cbr_cmd_t  cmd;
  cbr_stat_t stat;

  // Sequence the steps
  cbr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_item.valid),
    .in_ready  (in_item.ready),
    .out_valid (out_item.valid),
    .out_ready (out_item.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Bracket, multiplier and compare
  cbr_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_value  (in_item.value),
    .root      (out_item.root)
  );

endmodule
